FILE: hw/rtl/frequency_to_note_quantizer_unit_defines.svh
`ifndef FREQUENCY_TO_NOTE_QUANTIZER_UNIT_DEFINES_SVH
`define FREQUENCY_TO_NOTE_QUANTIZER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FNQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FNQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fnq_pkg.sv
package fnq_pkg;

    localparam int FREQ_W      = 23;
    localparam int MAG_W       = 22;
    localparam int NOTE_W      = 7;
    localparam int PC_W        = 4;
    localparam int OCT_W       = 5;
    localparam int ROM_DEPTH   = 128;
    localparam int ROM_AW      = 7;
    localparam int DIV12_SHIFT = 9;

    // 440 * 2^(r/12) Hz, unsigned Q.16
    localparam logic [31:0] SEMI_K [12] = '{
        32'd28835840, 32'd30550508, 32'd32367136, 32'd34291786,
        32'd36330882, 32'd38491228, 32'd40780036, 32'd43204943,
        32'd45774043, 32'd48495909, 32'd51379626, 32'd54434817
    };

    typedef logic [MAG_W-1:0] freq_rom_t [ROM_DEPTH];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SEARCH,
        ST_LO,
        ST_HI,
        ST_PICK,
        ST_DONE
    } fnq_state_t;

    typedef struct packed {
        logic [MAG_W:0] diff;
        logic           neg;
        logic           zero;
    } alu_res_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              bad;
    } note_res_t;

    // note i = 440 * 2^((i-69)/12) in Q14.8, rounded half up; note 0 sits at q = -6, r = 3
    function automatic freq_rom_t build_rom();
        freq_rom_t   rom;
        int          r;
        int          q;
        int          s;
        logic [31:0] k;
        r = 3;
        q = -6;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            s      = 8 - q;
            k      = SEMI_K[r] + (32'd1 << (s - 1));
            rom[i] = MAG_W'(k >> s);
            r++;
            if (r == 12)
            begin
                r = 0;
                q++;
            end
        end
        return rom;
    endfunction

    localparam freq_rom_t NOTE_ROM = build_rom();

endpackage

FILE: hw/rtl/fnq_alu.sv
module fnq_alu
    import fnq_pkg::*;
(
    input  logic [MAG_W-1:0] op_a,
    input  logic [MAG_W-1:0] op_b,
    output alu_res_t         res
);

    logic [MAG_W:0] diff;

    assign diff     = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff = diff;
    assign res.neg  = diff[MAG_W];
    assign res.zero = (diff == '0);

endmodule

FILE: hw/rtl/fnq_ctrl.sv
`include "frequency_to_note_quantizer_unit_defines.svh"

module fnq_ctrl
    import fnq_pkg::*;
#(
    parameter int NOTE_COUNT = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FREQ_W-1:0] frequency,
    input  logic              ack,
    output logic              busy,
    output logic              done,
    output note_res_t         result
);

    localparam int IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int CNT_W = $clog2(NOTE_COUNT + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NOTE_COUNT);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [NOTE_W-1:0] NOTE_TOP  = NOTE_W'(NOTE_COUNT - 1);
    localparam logic [NOTE_W-1:0] NOTE_ZERO = '0;

    fnq_state_t          state_reg, state_next;
    logic [MAG_W-1:0]    f_reg, f_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [MAG_W-1:0]    dl_reg, dl_next;
    logic [MAG_W-1:0]    du_reg, du_next;
    logic [NOTE_W-1:0]   note_reg, note_next;
    logic                bad_reg, bad_next;

    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    span_next;
    logic [IDX_W-1:0]    rom_addr;
    logic [MAG_W-1:0]    rom_val;
    logic [MAG_W-1:0]    op_a;
    logic [MAG_W-1:0]    op_b;
    logic                gt;
    alu_res_t            alu_res;

    fnq_alu u_alu
    (
        .op_a (op_a),
        .op_b (op_b),
        .res  (alu_res)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign rom_val = NOTE_ROM[ROM_AW'(rom_addr)];
    assign gt      = !alu_res.neg && !alu_res.zero;

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign result.note   = note_reg;
    assign result.bad    = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg    <= f_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        dl_reg   <= dl_next;
        du_reg   <= du_next;
        note_reg <= note_next;
        bad_reg  <= bad_next;
    end

    always_comb
    begin
        state_next = state_reg;
        f_next     = f_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        dl_next    = dl_reg;
        du_next    = du_reg;
        note_next  = note_reg;
        bad_next   = bad_reg;
        rom_addr   = '0;
        op_a       = f_reg;
        op_b       = rom_val;
        span_next  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    f_next   = frequency[MAG_W-1:0];
                    bad_next = frequency[FREQ_W-1];
                    if (frequency[FREQ_W-1])
                    begin
                        note_next  = NOTE_ZERO;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE:
            begin
                rom_addr = '0;
                if (gt)
                begin
                    lo_next    = '0;
                    hi_next    = CNT_FULL;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    note_next  = NOTE_ZERO;
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                rom_addr = mid[IDX_W-1:0];
                if (gt)
                begin
                    lo_next = mid;
                end
                else
                begin
                    hi_next = mid;
                end
                span_next = hi_next - lo_next;
                if (span_next == CNT_ONE)
                begin
                    if (hi_next == CNT_FULL)
                    begin
                        note_next  = NOTE_TOP;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LO;
                    end
                end
            end
            ST_LO:
            begin
                rom_addr   = lo_reg[IDX_W-1:0];
                dl_next    = alu_res.diff[MAG_W-1:0];
                state_next = ST_HI;
            end
            ST_HI:
            begin
                rom_addr   = hi_reg[IDX_W-1:0];
                op_a       = rom_val;
                op_b       = f_reg;
                du_next    = alu_res.diff[MAG_W-1:0];
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                op_a = dl_reg;
                op_b = du_reg;
                if (alu_res.neg)
                begin
                    note_next = NOTE_W'(lo_reg);
                end
                else
                begin
                    note_next = NOTE_W'(hi_reg);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FNQ_ASSERT_NOW(a_search_span, state_reg == ST_SEARCH, (hi_reg > lo_reg) && ((hi_reg - lo_reg) > CNT_ONE), "search window collapsed")
    `FNQ_ASSERT_NOW(a_hi_in_rom, (state_reg == ST_HI) || (state_reg == ST_PICK), hi_reg < CNT_FULL, "upper neighbour beyond last note")
    `FNQ_ASSERT_NOW(a_note_range, state_reg == ST_DONE, (note_reg <= NOTE_TOP) && (!bad_reg || note_reg == NOTE_ZERO), "note out of range or bad input not on note 0")
    `FNQ_ASSERT_NEXT(a_neg_short, (state_reg == ST_IDLE) && start && frequency[FREQ_W-1], (state_reg == ST_DONE) && bad_reg, "negative input did not finish at once")

endmodule

FILE: hw/rtl/frequency_to_note_quantizer_unit.sv
// Sequence: a negative input goes straight to the result; one at or below note 0 ends
//   after the base compare, one above the top note after the binary search, and any
//   other after the search and the LO, HI, PICK steps that pick the nearer neighbour.
// Flow: freq_stall holds a new input until the last note is loaded into the output;
//   the binary search runs one ROM compare a cycle through the single shared subtractor.
// Reset: rst_n asynchronous, active low; clears the sequencer and the output valid.
module frequency_to_note_quantizer_unit
    import fnq_pkg::*;
#(
    parameter int NOTE_COUNT = 128
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    freq_valid,
    output logic                    freq_stall,
    input  logic signed [FREQ_W-1:0] frequency,
    output logic                    note_valid,
    input  logic                    note_stall,
    output logic [NOTE_W-1:0]       note_number,
    output logic [PC_W-1:0]         pitch_class,
    output logic signed [OCT_W-1:0] octave,
    output logic                    bad_input
);

    logic                   start;
    logic                   busy;
    logic                   done;
    logic                   load;
    note_res_t              result;

    logic [12:0]            prod;
    logic [PC_W-1:0]        quot;
    logic [NOTE_W-1:0]      rem;

    logic                   note_valid_reg, note_valid_next;
    logic [NOTE_W-1:0]      note_reg;
    logic [PC_W-1:0]        pc_reg;
    logic [OCT_W-1:0]       oct_reg;
    logic                   bad_reg;

    assign freq_stall = busy;
    assign start      = freq_valid && !busy;
    assign load       = done && (!note_valid_reg || !note_stall);

    fnq_ctrl #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .frequency (frequency),
        .ack       (load),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    // n / 12 as (n * 43) >> 9, exact for n < 128
    assign prod = {6'b0, result.note} * 13'd43;
    assign quot = prod[12:DIV12_SHIFT];
    assign rem  = result.note - NOTE_W'({quot, 3'b000}) - NOTE_W'({quot, 2'b00});

    always_comb
    begin
        note_valid_next = note_valid_reg;
        if (load)
        begin
            note_valid_next = 1'b1;
        end
        else if (!note_stall)
        begin
            note_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_valid_reg <= 1'b0;
        end
        else
        begin
            note_valid_reg <= note_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            note_reg <= result.note;
            pc_reg   <= rem[PC_W-1:0];
            oct_reg  <= OCT_W'({1'b0, quot}) - OCT_W'(1);
            bad_reg  <= result.bad;
        end
    end

    assign note_valid  = note_valid_reg;
    assign note_number = note_reg;
    assign pitch_class = pc_reg;
    assign octave      = oct_reg;
    assign bad_input   = bad_reg;

endmodule

FILE: sim/fnq_note_checker.sv
module fnq_note_checker
    import fnq_pkg::*;
#(
    parameter int NOTE_COUNT = 128
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     freq_valid,
    input  logic                     freq_stall,
    input  logic signed [FREQ_W-1:0] frequency,
    input  logic                     note_valid,
    input  logic                     note_stall,
    input  logic [NOTE_W-1:0]        note_number,
    input  logic [PC_W-1:0]          pitch_class,
    input  logic signed [OCT_W-1:0]  octave,
    input  logic                     bad_input,
    output int                       mismatches,
    output int                       pending,
    output int                       notes_checked
);

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [PC_W-1:0]   pclass;
        logic [OCT_W-1:0]  oct;
        logic              bad;
    } note_expect_t;

    longint       note_hz_q8 [NOTE_COUNT];
    note_expect_t expected_notes [$];

    // 440 * 2^(r/12) Hz, Q.16
    function automatic longint semitone_q16(input int r);
        case (r)
            0:       return 64'd28835840;
            1:       return 64'd30550508;
            2:       return 64'd32367136;
            3:       return 64'd34291786;
            4:       return 64'd36330882;
            5:       return 64'd38491228;
            6:       return 64'd40780036;
            7:       return 64'd43204943;
            8:       return 64'd45774043;
            9:       return 64'd48495909;
            10:      return 64'd51379626;
            default: return 64'd54434817;
        endcase
    endfunction

    initial
    begin
        int d;
        int q;
        int s;
        for (int i = 0; i < NOTE_COUNT; i++)
        begin
            d = i - 69;
            q = (d >= 0) ? d / 12 : -((-d + 11) / 12);
            s = 8 - q;
            note_hz_q8[i] = (semitone_q16(d - 12 * q) + (64'd1 << (s - 1))) >> s;
        end
    end

    function automatic note_expect_t nearest_note(input logic signed [FREQ_W-1:0] f);
        note_expect_t e;
        longint       fv;
        int           n;
        int           v;
        fv    = f;
        n     = 0;
        e.bad = 1'b0;
        if (fv < 0)
            e.bad = 1'b1;
        else if (fv > note_hz_q8[0])
        begin
            v = 1;
            while (v < NOTE_COUNT && fv > note_hz_q8[v])
                v++;
            if (v == NOTE_COUNT)
                n = NOTE_COUNT - 1;
            else
                n = (fv - note_hz_q8[v-1] < note_hz_q8[v] - fv) ? v - 1 : v;  // tie goes up
        end
        e.note   = NOTE_W'(n);
        e.pclass = PC_W'(n % 12);
        e.oct    = OCT_W'(n / 12 - 1);
        return e;
    endfunction

    task automatic report_field(input string field, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches    = 0;
        pending       = 0;
        notes_checked = 0;
    end

    always @(posedge clk)
    begin
        note_expect_t e;
        if (rst_n)
        begin
            if (note_valid && !note_stall)
            begin
                if (expected_notes.size() == 0)
                begin
                    $display("%0t: unexpected note transaction, expected none, actual note %0d",
                             $time, note_number);
                    mismatches++;
                end
                else
                begin
                    e = expected_notes.pop_front();
                    report_field("note_number", e.note, note_number);
                    report_field("pitch_class", e.pclass, pitch_class);
                    report_field("octave", int'($signed(e.oct)), int'(octave));
                    report_field("bad_input", e.bad, bad_input);
                    notes_checked++;
                end
            end
            if (freq_valid && !freq_stall)
                expected_notes.push_back(nearest_note(frequency));
            pending = expected_notes.size();
        end
    end

endmodule

FILE: sim/tb.sv
module tb;
    import fnq_pkg::*;

    localparam int NOTE_COUNT     = 128;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_ITEMS   = 430;
    localparam int CALM_FROM      = 370;

    logic                     clk;
    logic                     rst_n;
    logic                     freq_valid;
    logic                     freq_stall;
    logic signed [FREQ_W-1:0] frequency;
    logic                     note_valid;
    logic                     note_stall;
    logic [NOTE_W-1:0]        note_number;
    logic [PC_W-1:0]          pitch_class;
    logic signed [OCT_W-1:0]  octave;
    logic                     bad_input;

    int mismatches;
    int pending;
    int notes_checked;
    int idle_cycles;
    int freqs_sent;
    int negatives_sent;
    int above_top_sent;
    bit idling;

    frequency_to_note_quantizer_unit #(
        .NOTE_COUNT(NOTE_COUNT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .freq_valid(freq_valid),
        .freq_stall(freq_stall),
        .frequency(frequency),
        .note_valid(note_valid),
        .note_stall(note_stall),
        .note_number(note_number),
        .pitch_class(pitch_class),
        .octave(octave),
        .bad_input(bad_input)
    );

    fnq_note_checker #(
        .NOTE_COUNT(NOTE_COUNT)
    ) i_chk (
        .clk(clk),
        .rst_n(rst_n),
        .freq_valid(freq_valid),
        .freq_stall(freq_stall),
        .frequency(frequency),
        .note_valid(note_valid),
        .note_stall(note_stall),
        .note_number(note_number),
        .pitch_class(pitch_class),
        .octave(octave),
        .bad_input(bad_input),
        .mismatches(mismatches),
        .pending(pending),
        .notes_checked(notes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (freq_valid && !freq_stall) || (note_valid && !note_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, no transaction for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                note_stall <= 1'b1;
                burst--;
            end
            else if (idling && rst_n && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 4) - 1;
                note_stall <= 1'b1;
            end
            else
                note_stall <= 1'b0;
        end
    end

    task automatic send_freq(input logic signed [FREQ_W-1:0] f);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            freq_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        freq_valid <= 1'b1;
        frequency  <= f;
        @(posedge clk);
        while (freq_stall)
            @(posedge clk);
        @(negedge clk);
        freqs_sent++;
        if (f < 0)
            negatives_sent++;
        else if (int'(f) > int'(NOTE_ROM[NOTE_COUNT-1]))
            above_top_sent++;
    endtask

    task automatic drain_notes();
        freq_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic signed [FREQ_W-1:0] directed [$];
        int lo;
        int hi;
        int idx;
        int kind;
        int val;
        rst_n          = 1'b0;
        freq_valid     = 1'b0;
        frequency      = '0;
        note_stall     = 1'b0;
        idle_cycles    = 0;
        freqs_sent     = 0;
        negatives_sent = 0;
        above_top_sent = 0;
        idling         = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        directed.push_back(FREQ_W'(0));
        directed.push_back(FREQ_W'(1));
        directed.push_back(FREQ_W'(256));
        directed.push_back(FREQ_W'(NOTE_ROM[0] - 1));
        directed.push_back(FREQ_W'(NOTE_ROM[0]));
        directed.push_back(FREQ_W'(NOTE_ROM[0] + 1));
        directed.push_back(FREQ_W'((NOTE_ROM[0] + NOTE_ROM[1]) / 2));
        directed.push_back(FREQ_W'((NOTE_ROM[0] + NOTE_ROM[1]) / 2 + 1));
        directed.push_back(FREQ_W'(440 * 256));
        directed.push_back(FREQ_W'(NOTE_ROM[69] + 1));
        directed.push_back(FREQ_W'((NOTE_ROM[68] + NOTE_ROM[69]) / 2));
        directed.push_back(FREQ_W'((NOTE_ROM[68] + NOTE_ROM[69]) / 2 + 1));
        directed.push_back(FREQ_W'((NOTE_ROM[126] + NOTE_ROM[127]) / 2));
        directed.push_back(FREQ_W'(NOTE_ROM[NOTE_COUNT-1]));
        directed.push_back(FREQ_W'(NOTE_ROM[NOTE_COUNT-1] + 1));
        directed.push_back(FREQ_W'(4194303));
        directed.push_back(FREQ_W'(-1));
        directed.push_back(FREQ_W'(-4194304));
        directed.push_back(FREQ_W'(-440 * 256));
        // exact midpoints between neighbours, each also one below, while under 23 directed frequencies
        for (int i = 0; i < NOTE_COUNT - 1; i++)
            if ((int'(NOTE_ROM[i]) + int'(NOTE_ROM[i+1])) % 2 == 0 && directed.size() < 23)
            begin
                directed.push_back(FREQ_W'((int'(NOTE_ROM[i]) + int'(NOTE_ROM[i+1])) / 2));
                directed.push_back(FREQ_W'((int'(NOTE_ROM[i]) + int'(NOTE_ROM[i+1])) / 2 - 1));
            end
        foreach (directed[i])
            send_freq(directed[i]);
        drain_notes();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CALM_FROM)
                idling = 1'b0;
            if (n == RANDOM_ITEMS / 2)
                drain_notes();
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                idx = $urandom_range(0, NOTE_COUNT - 2);
                lo  = NOTE_ROM[idx];
                hi  = NOTE_ROM[idx+1];
                case ($urandom_range(0, 2))
                    0:       val = lo;
                    1:       val = hi;
                    default: val = (lo + hi) / 2;
                endcase
                val = val + $urandom_range(0, 4) - 2;
            end
            else if (kind <= 6)
                val = $urandom_range(0, NOTE_ROM[NOTE_COUNT-1] + 1000);
            else if (kind == 7)
                val = $signed(FREQ_W'($urandom));
            else if (kind == 8)
                val = -$urandom_range(1, 4194304);
            else
                val = $urandom_range(NOTE_ROM[NOTE_COUNT-1] + 1, 4194303);
            send_freq(FREQ_W'(val));
        end

        freq_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        $display("Run covered %0d frequencies: %0d negative, %0d above the top note.",
                 freqs_sent, negatives_sent, above_top_sent);
        $display("%0d note transactions checked, %0d mismatches.", notes_checked, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
